### src/tsrt_pkg.sv
// ----------------------------------------------------------------------------
// Time slot reservation table package
// Shared types, codes and constants of the reservation table.
// ----------------------------------------------------------------------------
package tsrt_pkg;

    localparam int NUM_AREAS_DEF      = 16;
    localparam int SLOTS_PER_AREA_DEF = 32;
    localparam int MAX_SPAN           = 100;

    localparam int TIME_W  = 16;
    localparam int SPAN_W  = 7;
    localparam int AGENT_W = 8;
    // times grow past 16 bits while walking the table
    localparam int EXT_W   = TIME_W + 1;

    localparam logic [2:0] OP_ENABLE  = 3'd0;
    localparam logic [2:0] OP_RESERVE = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_SET_LEN = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNKNOWN  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [TIME_W-1:0]  start;
        logic [SPAN_W-1:0]  span;
        logic [AGENT_W-1:0] owner;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_CHECK,
        S_EMIT
    } state_t;

endpackage

### src/tsrt_ram.sv
// ----------------------------------------------------------------------------
// Generic single port RAM
// One access per cycle: it always reads, writes too when we is high, registered read data.
// ----------------------------------------------------------------------------
module tsrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

### src/tsrt_cell.sv
// ----------------------------------------------------------------------------
// Reservation table cell
// Holds one entry of the working copy; shifts toward the head on demand and,
// when its index is below the entry count, flags a start time equal to the broadcast key.
// ----------------------------------------------------------------------------
module tsrt_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 6
) (
    input  logic            clk,
    input  logic            shift,
    input  tsrt_pkg::entry_t shift_in,
    input  logic [CW-1:0]   count,
    input  logic [15:0]     key,
    output tsrt_pkg::entry_t entry,
    output logic            hit
);
    import tsrt_pkg::*;

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= shift_in;
        end
    end

    assign entry = entry_reg;
    assign hit   = (CW'(INDEX) < count) && (entry_reg.start == key);

endmodule

### src/tsrt_walk.sv
// ----------------------------------------------------------------------------
// First-fit walk unit
// Takes the area's entries in ascending order, one per cycle while valid is high, and
// moves the candidate time past every entry it overlaps.
// ----------------------------------------------------------------------------
module tsrt_walk (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        init,
    input  logic [15:0]                 slot_time,
    input  logic [6:0]                  len,
    input  logic                        valid,
    input  tsrt_pkg::entry_t            entry,
    output logic [tsrt_pkg::EXT_W-1:0]  grant
);
    import tsrt_pkg::*;

    logic [EXT_W-1:0] t_reg, t_next;
    logic             stop_reg, stop_next;
    logic [EXT_W-1:0] b, e, f;
    logic             overlap;

    always_comb
    begin
        b = EXT_W'(entry.start);
        e = b + EXT_W'(entry.span);
        f = t_reg + EXT_W'(len);
        overlap = ((t_reg >= b) && (t_reg < e)) || ((f >= b) && (f < e))
                  || ((t_reg <= b) && (f >= e));
        t_next    = t_reg;
        stop_next = stop_reg;
        if (init)
        begin
            t_next    = EXT_W'(slot_time);
            stop_next = 1'b0;
        end
        else if (valid && !stop_reg)
        begin
            if (f <= b)
            begin
                stop_next = 1'b1;
            end
            else if (overlap)
            begin
                t_next = e;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg    <= '0;
            stop_reg <= 1'b0;
        end
        else
        begin
            t_reg    <= t_next;
            stop_reg <= stop_next;
        end
    end

    assign grant = t_reg;

endmodule

### src/time_slot_reservation_table.sv
// One request at a time: the area's table is copied through the single RAM port
// into the cell chain and back. Results are one-cycle strobes on done, given while
// busy is low; an opcode above OP_CLEAR returns to idle with no strobe.
// Reset clears all area enables and entry counts; the table RAM is not cleared.
// ----------------------------------------------------------------------------
// Time slot reservation table
// Per-area sorted reservation tables with first-fit placement.
// ----------------------------------------------------------------------------
module time_slot_reservation_table #(
    parameter int NUM_AREAS      = tsrt_pkg::NUM_AREAS_DEF,
    parameter int SLOTS_PER_AREA = tsrt_pkg::SLOTS_PER_AREA_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [3:0]  area,
    input  logic [7:0]  agent,
    input  logic [15:0] request_tag,
    input  logic [15:0] slot_time,
    input  logic [15:0] span,
    output logic        done,
    output logic [2:0]  status,
    output logic        mismatch,
    output logic [3:0]  area_out,
    output logic [7:0]  agent_out,
    output logic [15:0] tag_out,
    output logic [15:0] granted_time,
    output logic [6:0]  granted_span
);
    import tsrt_pkg::*;

    localparam int S   = SLOTS_PER_AREA;
    localparam int CW  = $clog2(S + 1);
    localparam int AW  = $clog2(NUM_AREAS * S);
    localparam int AIW = (NUM_AREAS > 1) ? $clog2(NUM_AREAS) : 1;

    state_t state_reg, state_next;

    logic [2:0]  op_reg, op_next;
    logic [3:0]  area_reg, area_next;
    logic [7:0]  agent_reg, agent_next;
    logic [15:0] tag_reg, tag_next;
    logic [15:0] time_reg, time_next;
    logic [6:0]  len_reg, len_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] lc_reg, lc_next;
    logic          dv_reg, dv_next;
    logic [CW-1:0] didx_reg, didx_next;
    logic [CW-1:0] s_reg, s_next;
    logic [CW-1:0] wa_reg, wa_next;
    logic          ins_reg, ins_next;
    logic          done_reg, done_next;
    logic [2:0]    status_reg, status_next;
    logic          mis_reg, mis_next;
    logic [15:0]   gtime_reg, gtime_next;
    logic [6:0]    gspan_reg, gspan_next;
    logic          en_reg [NUM_AREAS];
    logic          en_next [NUM_AREAS];
    logic [CW-1:0] cnt_reg [NUM_AREAS];
    logic [CW-1:0] cnt_next [NUM_AREAS];

    logic [AIW-1:0] aidx;
    logic           in_range;
    logic           known;
    logic [AW-1:0]  base;
    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    entry_t         ram_wdata;
    entry_t         ram_rdata;
    logic           shift;
    logic           walk_init;
    logic           walk_valid;
    logic [EXT_W-1:0] grant;
    logic [15:0]    key;
    entry_t         cell_q [S];
    logic [S-1:0]   cell_hit;
    logic           hit;
    entry_t         head;
    logic           have;
    logic           match;
    entry_t         new_entry;

    assign aidx     = AIW'(area_reg);
    assign in_range = 32'(area_reg) < NUM_AREAS;
    assign known    = in_range && ((op_reg == OP_ENABLE) || en_reg[aidx]);
    assign base     = AW'(aidx) * AW'(S);
    assign head     = cell_q[0];
    assign have     = s_reg != n_reg;
    assign match    = have && (head.start == gtime_reg);
    assign hit      = |cell_hit;
    assign key      = (op_reg == OP_RESERVE) ? grant[15:0] : time_reg;
    assign new_entry = '{start: gtime_reg, span: len_reg, owner: agent_reg};
    assign walk_valid = dv_reg && (didx_reg < n_reg);

    tsrt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_AREAS * S)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    tsrt_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .init      (walk_init),
        .slot_time (time_reg),
        .len       (len_reg),
        .valid     (walk_valid),
        .entry     (ram_rdata),
        .grant     (grant)
    );

    genvar k;
    generate
        for (k = 0; k < S; k++)
        begin : g_cell
            entry_t nb;
            if (k == S - 1)
            begin : g_tail
                assign nb = ram_rdata;
            end
            else
            begin : g_mid
                assign nb = cell_q[k+1];
            end
            tsrt_cell #(
                .INDEX (k),
                .CW    (CW)
            ) u_cell (
                .clk      (clk),
                .shift    (shift),
                .shift_in (nb),
                .count    (n_reg),
                .key      (key),
                .entry    (cell_q[k]),
                .hit      (cell_hit[k])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (op_reg > OP_CLEAR || op_reg == OP_CLEAR || !known
                    || op_reg == OP_ENABLE)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (lc_reg == CW'(S))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (op_reg == OP_RESERVE)
                begin
                    if (grant[EXT_W-1] || (!hit && n_reg == CW'(S)))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else if (!hit)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!have && (op_reg != OP_RESERVE || ins_reg))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next     = op_reg;
        area_next   = area_reg;
        agent_next  = agent_reg;
        tag_next    = tag_reg;
        time_next   = time_reg;
        len_next    = len_reg;
        n_next      = n_reg;
        lc_next     = lc_reg;
        dv_next     = 1'b0;
        didx_next   = lc_reg;
        s_next      = s_reg;
        wa_next     = wa_reg;
        ins_next    = ins_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        mis_next    = mis_reg;
        gtime_next  = gtime_reg;
        gspan_next  = gspan_reg;
        en_next     = en_reg;
        cnt_next    = cnt_reg;
        ram_we      = 1'b0;
        ram_addr    = base + AW'(wa_reg);
        ram_wdata   = head;
        shift       = 1'b0;
        walk_init   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = opcode;
                    area_next  = area;
                    agent_next = agent;
                    tag_next   = request_tag;
                    time_next  = slot_time;
                    len_next   = (32'(span) > MAX_SPAN) ? 7'(MAX_SPAN) : span[6:0];
                end
            end
            S_DECODE:
            begin
                status_next = ST_OK;
                mis_next    = 1'b0;
                gtime_next  = '0;
                gspan_next  = '0;
                walk_init   = 1'b1;
                lc_next     = '0;
                n_next      = cnt_reg[aidx];
                if (op_reg == OP_CLEAR)
                begin
                    done_next = 1'b1;
                    for (int i = 0; i < NUM_AREAS; i++)
                    begin
                        en_next[i]  = 1'b0;
                        cnt_next[i] = '0;
                    end
                end
                else if (op_reg > OP_CLEAR)
                begin
                    done_next = 1'b0;
                end
                else if (!known)
                begin
                    done_next   = 1'b1;
                    status_next = ST_UNKNOWN;
                end
                else if (op_reg == OP_ENABLE)
                begin
                    done_next     = 1'b1;
                    en_next[aidx] = 1'b1;
                end
            end
            S_LOAD:
            begin
                ram_addr = base + AW'(lc_reg);
                shift    = dv_reg;
                if (lc_reg != CW'(S))
                begin
                    lc_next = lc_reg + 1'b1;
                    dv_next = 1'b1;
                end
            end
            S_CHECK:
            begin
                s_next   = '0;
                wa_next  = '0;
                ins_next = 1'b0;
                if (op_reg == OP_RESERVE)
                begin
                    gtime_next = grant[15:0];
                    gspan_next = len_reg;
                    if (grant[EXT_W-1])
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OVERFLOW;
                        gtime_next  = '0;
                        gspan_next  = '0;
                    end
                    else if (!hit && n_reg == CW'(S))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FULL;
                        gtime_next  = '0;
                        gspan_next  = '0;
                    end
                end
                else
                begin
                    gtime_next = time_reg;
                    gspan_next = (op_reg == OP_SET_LEN) ? len_reg : 7'd0;
                    if (!hit)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_NOTFOUND;
                        gtime_next  = '0;
                        gspan_next  = '0;
                    end
                end
            end
            S_EMIT:
            begin
                if (op_reg == OP_RESERVE)
                begin
                    if (!ins_reg && (!have || head.start > gtime_reg))
                    begin
                        // new entry goes in ahead of the head
                        ram_we    = 1'b1;
                        ram_wdata = new_entry;
                        wa_next   = wa_reg + 1'b1;
                        ins_next  = 1'b1;
                    end
                    else if (have)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = match ? new_entry : head;
                        wa_next   = wa_reg + 1'b1;
                        shift     = 1'b1;
                        s_next    = s_reg + 1'b1;
                        if (match)
                        begin
                            ins_next = 1'b1;
                        end
                    end
                end
                else if (have)
                begin
                    shift  = 1'b1;
                    s_next = s_reg + 1'b1;
                    if (match)
                    begin
                        mis_next = head.owner != agent_reg;
                    end
                    if (op_reg == OP_RELEASE)
                    begin
                        if (match)
                        begin
                            gspan_next = head.span;
                        end
                        else
                        begin
                            ram_we  = 1'b1;
                            wa_next = wa_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ram_we  = 1'b1;
                        wa_next = wa_reg + 1'b1;
                        if (match)
                        begin
                            ram_wdata.span = len_reg;
                        end
                    end
                end
                if (!have && (op_reg != OP_RESERVE || ins_reg))
                begin
                    done_next     = 1'b1;
                    cnt_next[aidx] = wa_reg;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            dv_reg    <= 1'b0;
            lc_reg    <= '0;
            s_reg     <= '0;
            wa_reg    <= '0;
            ins_reg   <= 1'b0;
            n_reg     <= '0;
            for (int i = 0; i < NUM_AREAS; i++)
            begin
                en_reg[i]  <= 1'b0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            dv_reg    <= dv_next;
            lc_reg    <= lc_next;
            s_reg     <= s_next;
            wa_reg    <= wa_next;
            ins_reg   <= ins_next;
            n_reg     <= n_next;
            en_reg    <= en_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        area_reg   <= area_next;
        agent_reg  <= agent_next;
        tag_reg    <= tag_next;
        time_reg   <= time_next;
        len_reg    <= len_next;
        didx_reg   <= didx_next;
        status_reg <= status_next;
        mis_reg    <= mis_next;
        gtime_reg  <= gtime_next;
        gspan_reg  <= gspan_next;
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign status       = status_reg;
    assign mismatch     = mis_reg;
    assign area_out     = area_reg;
    assign agent_out    = agent_reg;
    assign tag_out      = tag_reg;
    assign granted_time = gtime_reg;
    assign granted_span = gspan_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (granted_time == '0 && granted_span == '0 && !mismatch))
        else $error("error result carries data");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (n_reg <= CW'(S)))
        else $error("entry count beyond table size");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (s_reg <= n_reg && wa_reg <= CW'(S)))
        else $error("chain pointer out of range");

endmodule
